@@ rtl/core/pmc_pkg.sv @@
// pan-law matrix coefficient package: widths, payload types, opcodes and
// the quarter-wave sine table builder evaluated at elaboration
// no dependencies

package pmc_pkg;

  typedef longint unsigned u64_t;

  // table and gain format
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int GAIN_FRAC_BITS   = 15;

  localparam int PAN_W      = 16;
  localparam int PHASE_W    = 16;
  localparam int PHASE_FRAC = 15;
  localparam int GAIN_W     = 16;
  localparam int Q30_FRAC   = 30;
  localparam int Q30_W      = Q30_FRAC + 1;
  localparam int ADDR_W     = $clog2(SINE_TABLE_DEPTH + 1);

  localparam int PAN_FULL   = 16384;
  localparam int PHASE_FULL = 32768;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam u64_t Q30_ONE64   = 64'd1 << Q30_FRAC;
  localparam u64_t HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [PAN_W-1:0] pan_t;
  typedef logic [PHASE_W-1:0]      phase_t;
  typedef logic [GAIN_W-1:0]       gain_t;
  typedef logic [Q30_W-1:0]        q30_t;
  typedef logic [ADDR_W-1:0]       sine_addr_t;

  localparam q30_t Q30_ONE = q30_t'(Q30_ONE64);

  // opcodes
  localparam logic OP_MONO    = 1'b0;
  localparam logic OP_BALANCE = 1'b1;

  typedef struct packed {
    gain_t gain_left_to_left;
    gain_t gain_right_to_left;
    gain_t gain_left_to_right;
    gain_t gain_right_to_right;
  } pmc_gains_t;

  typedef q30_t sine_tab_t [0:SINE_TABLE_DEPTH];

  // restoring long division for the table build; elaboration only
  function automatic u64_t elab_div(u64_t num, u64_t den);
    u64_t quo;
    u64_t rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // integer taylor series, each term truncated at q30; elaboration only
  function automatic q30_t taylor_sine(u64_t x);
    u64_t   x2;
    u64_t   term;
    longint sum;
    x2   = (x * x) >> Q30_FRAC;
    term = x;
    sum  = 0;
    for (int n = 0; n < 24; n++) begin
      if ((n & 1) == 0) begin
        sum = sum + longint'(term);
      end else begin
        sum = sum - longint'(term);
      end
      term = elab_div((term * x2) >> Q30_FRAC, u64_t'((2 * n + 2) * (2 * n + 3)));
    end
    if (sum < 0) begin
      return '0;
    end
    if (u64_t'(sum) > Q30_ONE64) begin
      return Q30_ONE;
    end
    return q30_t'(sum);
  endfunction

  // entry k holds sin(pi/2 * k / depth), forced non-decreasing
  function automatic sine_tab_t build_sine_table();
    sine_tab_t tab;
    u64_t      x;
    q30_t      v;
    tab[0] = '0;
    for (int k = 1; k < SINE_TABLE_DEPTH; k++) begin
      x = (HALF_PI_Q30 * u64_t'(k) + u64_t'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
      v = taylor_sine(x);
      if (v < tab[k-1]) begin
        v = tab[k-1];
      end
      tab[k] = v;
    end
    tab[SINE_TABLE_DEPTH] = Q30_ONE;
    return tab;
  endfunction

endpackage

@@ rtl/core/pmc_if.sv @@
// item channels of the pan-law block: pan/opcode in, four gains out
// depends on pmc_pkg

interface pmc_in_if import pmc_pkg::*; ();
  logic valid;
  logic ready;
  pan_t pan_position;
  logic opcode;

  modport source (output valid, output pan_position, output opcode, input ready);
  modport sink   (input valid, input pan_position, input opcode, output ready);
endinterface

interface pmc_out_if import pmc_pkg::*; ();
  logic  valid;
  logic  ready;
  gain_t gain_left_to_left;
  gain_t gain_right_to_left;
  gain_t gain_left_to_right;
  gain_t gain_right_to_right;

  modport source (output valid, output gain_left_to_left, output gain_right_to_left,
                  output gain_left_to_right, output gain_right_to_right, input ready);
  modport sink   (input valid, input gain_left_to_left, input gain_right_to_left,
                  input gain_left_to_right, input gain_right_to_right, output ready);
endinterface

@@ rtl/core/pan_law_matrix_coefficients.sv @@
// pan-law matrix coefficients: top level
// depends on pmc_pkg, pmc_if, pmc_quarter_sine and pmc_out_fifo
//
//   channel   dir  handshake     payload
//   in_chan   in   valid/ready   pan_position (s16 q2.14), opcode (1)
//   out_chan  out  valid/ready   gain_left_to_left, gain_right_to_left,
//                                gain_left_to_right, gain_right_to_right (u16 q1.15)
//
// one item per cycle while in_chan.ready is high; a taken item passes the phase
// register, table read, slope multiply, interpolation and the result queue
// the sine table is a constant rom, so reset only clears the valid pipe,
// the occupancy count and the queue pointers and count; no fill sweep is needed
// an 8-entry result queue absorbs output stalls; in_chan.ready drops once
// eight items are taken and not yet delivered

module pan_law_matrix_coefficients import pmc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pmc_in_if.sink    in_chan,
  pmc_out_if.source out_chan
);

  localparam int PIPE_D     = 4;
  localparam int GAIN_SHIFT = Q30_FRAC - GAIN_FRAC_BITS;

  localparam logic [Q30_W:0] RND_LO = (Q30_W + 1)'((64'd1 << GAIN_SHIFT) >> 1);
  localparam logic [Q30_W:0] RND_HI = (Q30_W + 1)'(64'd1 << GAIN_SHIFT);

  localparam pan_t PAN_POS_FULL = pan_t'(PAN_FULL);
  localparam pan_t PAN_NEG_FULL = pan_t'(-PAN_FULL);

  // which gains the two sine lanes land in
  typedef enum logic [1:0] {
    ROUTE_MONO,
    ROUTE_BAL_NEG,
    ROUTE_BAL_POS
  } route_t;

  // q30 to output gain, rounded half up, halved for the balance law
  function automatic gain_t to_gain(q30_t v, logic halve);
    logic [Q30_W:0] sh_lo;
    logic [Q30_W:0] sh_hi;
    sh_lo = ({1'b0, v} + RND_LO) >> GAIN_SHIFT;
    sh_hi = ({1'b0, v} + RND_HI) >> (GAIN_SHIFT + 1);
    return halve ? sh_hi[GAIN_W-1:0] : sh_lo[GAIN_W-1:0];
  endfunction

  logic                  accept;
  logic                  pop;
  logic [FIFO_CNT_W-1:0] occ_r;
  logic [FIFO_CNT_W-1:0] occ_nxt;

  pan_t   pan_sat;
  phase_t ph_mono;
  phase_t pan_mag;
  phase_t ph_bal;
  phase_t ph_sin;
  route_t route_in;

  phase_t      ph_sin_r;
  phase_t      ph_cos_r;
  logic [PIPE_D-1:0] v_r;
  route_t      route_r [PIPE_D];

  q30_t       sin_val;
  q30_t       cos_val;
  q30_t       ll_q;
  q30_t       rl_q;
  q30_t       lr_q;
  q30_t       rr_q;
  logic       halve;
  pmc_gains_t gains;

  // ---- intake: credit count covers the pipe and the result queue
  assign accept        = in_chan.valid && in_chan.ready;
  assign pop           = out_chan.valid && out_chan.ready;
  assign in_chan.ready = (occ_r != FIFO_CNT_W'(FIFO_DEPTH));
  assign occ_nxt       = occ_r + FIFO_CNT_W'(accept) - FIFO_CNT_W'(pop);

  // ---- pan saturation and phase selection
  always_comb begin
    if (in_chan.pan_position > PAN_POS_FULL) begin
      pan_sat = PAN_POS_FULL;
    end else if (in_chan.pan_position < PAN_NEG_FULL) begin
      pan_sat = PAN_NEG_FULL;
    end else begin
      pan_sat = in_chan.pan_position;
    end
  end

  // mono: phase is pan + 1 over the quarter wave
  assign ph_mono = phase_t'(pan_sat) + phase_t'(PAN_FULL);
  // balance: phase is twice the pan magnitude
  assign pan_mag = pan_sat[PAN_W-1] ? phase_t'(-pan_sat) : phase_t'(pan_sat);
  assign ph_bal  = {pan_mag[PHASE_W-2:0], 1'b0};
  assign ph_sin  = (in_chan.opcode == OP_MONO) ? ph_mono : ph_bal;

  always_comb begin
    if (in_chan.opcode == OP_MONO) begin
      route_in = ROUTE_MONO;
    end else if (pan_sat[PAN_W-1]) begin
      route_in = ROUTE_BAL_NEG;
    end else begin
      route_in = ROUTE_BAL_POS;
    end
  end

  // ---- control and valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      v_r   <= '0;
    end else begin
      occ_r <= occ_nxt;
      v_r   <= {v_r[PIPE_D-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    ph_sin_r   <= ph_sin;
    ph_cos_r   <= phase_t'(PHASE_FULL) - ph_sin;
    route_r[0] <= route_in;
    for (int i = 1; i < PIPE_D; i++) begin
      route_r[i] <= route_r[i-1];
    end
  end

  // ---- sine lanes: sin(u) and cos(u) = sin(full - u)
  pmc_quarter_sine u_sin (
    .clk     (clk),
    .phase   (ph_sin_r),
    .value_r (sin_val)
  );

  pmc_quarter_sine u_cos (
    .clk     (clk),
    .phase   (ph_cos_r),
    .value_r (cos_val)
  );

  // ---- matrix assembly
  always_comb begin
    case (route_r[PIPE_D-1])
      ROUTE_MONO: begin
        ll_q = cos_val;
        rl_q = '0;
        lr_q = '0;
        rr_q = sin_val;
      end
      ROUTE_BAL_NEG: begin
        // left held at unity, right pulled in
        ll_q = Q30_ONE;
        rl_q = sin_val;
        lr_q = '0;
        rr_q = cos_val;
      end
      ROUTE_BAL_POS: begin
        // right held at unity, left pulled in
        ll_q = cos_val;
        rl_q = '0;
        lr_q = sin_val;
        rr_q = Q30_ONE;
      end
      default: begin
        ll_q = '0;
        rl_q = '0;
        lr_q = '0;
        rr_q = '0;
      end
    endcase
  end

  assign halve = (route_r[PIPE_D-1] != ROUTE_MONO);

  assign gains.gain_left_to_left   = to_gain(ll_q, halve);
  assign gains.gain_right_to_left  = to_gain(rl_q, halve);
  assign gains.gain_left_to_right  = to_gain(lr_q, halve);
  assign gains.gain_right_to_right = to_gain(rr_q, halve);

  // ---- result queue
  pmc_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (v_r[PIPE_D-1]),
    .push_gains (gains),
    .out_chan   (out_chan)
  );

  // ---- checks
  // credit count never passes the queue depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("occupancy above queue depth");

  // a deliverable result is always backed by a counted item
  a_out_backed: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (occ_r != '0))
    else $error("result offered with no item in flight");

  // every item taken reaches the queue after the fixed pipe depth
  a_pipe_len: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##PIPE_D v_r[PIPE_D-1])
    else $error("item lost in coefficient pipe");

  // the mono law never drives the cross gains
  a_mono_cross: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[PIPE_D-1] && (route_r[PIPE_D-1] == ROUTE_MONO)) |->
      ((gains.gain_right_to_left == '0) && (gains.gain_left_to_right == '0)))
    else $error("cross gain set under mono law");

endmodule

@@ rtl/core/pmc_sine_rom.sv @@
// quarter-wave sine rom, two read ports with registered data
// depends on pmc_pkg

module pmc_sine_rom import pmc_pkg::*; (
  input  logic       clk,
  input  sine_addr_t addr_a,
  input  sine_addr_t addr_b,
  output q30_t       data_a_r,
  output q30_t       data_b_r
);

  localparam sine_tab_t SINE_ROM = build_sine_table();

  always_ff @(posedge clk) begin
    data_a_r <= SINE_ROM[addr_a];
    data_b_r <= SINE_ROM[addr_b];
  end

endmodule

@@ rtl/core/pmc_quarter_sine.sv @@
// three-stage quarter-wave sine: table read, slope multiply, interpolate
// depends on pmc_pkg and pmc_sine_rom

module pmc_quarter_sine import pmc_pkg::*; (
  input  logic   clk,
  input  phase_t phase,
  output q30_t   value_r
);

  localparam int POS_W  = PHASE_W + ADDR_W;
  localparam int PROD_W = Q30_W + PHASE_FRAC;

  logic [POS_W-1:0]      pos;
  sine_addr_t            idx_lo;
  sine_addr_t            idx_hi;
  logic [PHASE_FRAC-1:0] frac;
  logic [PHASE_FRAC-1:0] frac_r;
  q30_t                  tab_lo;
  q30_t                  tab_hi;
  logic [PROD_W-1:0]     prod_r;
  q30_t                  base_r;
  logic [PROD_W-1:0]     interp_sum;

  // table position of the phase
  assign pos    = POS_W'(phase) * POS_W'(SINE_TABLE_DEPTH);
  assign idx_lo = pos[PHASE_FRAC +: ADDR_W];
  assign frac   = pos[PHASE_FRAC-1:0];
  // at the top of the quarter wave the fraction is zero
  assign idx_hi = (idx_lo == ADDR_W'(SINE_TABLE_DEPTH)) ? idx_lo : idx_lo + 1'b1;

  pmc_sine_rom u_rom (
    .clk      (clk),
    .addr_a   (idx_lo),
    .addr_b   (idx_hi),
    .data_a_r (tab_lo),
    .data_b_r (tab_hi)
  );

  assign interp_sum = prod_r + PROD_W'(1 << (PHASE_FRAC - 1));

  always_ff @(posedge clk) begin
    frac_r  <= frac;
    prod_r  <= PROD_W'(tab_hi - tab_lo) * PROD_W'(frac_r);
    base_r  <= tab_lo;
    value_r <= base_r + interp_sum[PHASE_FRAC +: Q30_W];
  end

endmodule

@@ rtl/core/pmc_out_fifo.sv @@
// result queue between the coefficient pipeline and the output channel
// depends on pmc_pkg and pmc_if

module pmc_out_fifo import pmc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  pmc_gains_t push_gains,
  pmc_out_if.source  out_chan
);

  pmc_gains_t            mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic [FIFO_CNT_W-1:0] cnt_nxt;
  logic                  pop;
  pmc_gains_t            head;

  assign pop  = out_chan.valid && out_chan.ready;
  assign head = mem_r[rd_ptr_r];

  assign out_chan.valid               = (cnt_r != '0);
  assign out_chan.gain_left_to_left   = head.gain_left_to_left;
  assign out_chan.gain_right_to_left  = head.gain_right_to_left;
  assign out_chan.gain_left_to_right  = head.gain_left_to_right;
  assign out_chan.gain_right_to_right = head.gain_right_to_right;

  assign cnt_nxt = cnt_r + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_gains;
    end
  end

endmodule

@@ verif/tb_pan_law_matrix_coefficients.sv @@
`timescale 1ns / 100ps
// self-checking bench for pan_law_matrix_coefficients: directed and random pan items in,
// four matrix gains out, each checked in order against an independent fixed-point predictor
// depends on pmc_pkg, pmc_if and the rtl top level

module tb_pan_law_matrix_coefficients;
  import pmc_pkg::*;

  typedef longint unsigned q30_word_t;

  // one pending pan request for the driver
  typedef struct {
    pan_t pan;
    logic op;
  } pan_item_t;

  // receiver stall behaviors, rotated through the run
  typedef enum int {RX_FREE, RX_COIN, RX_STARVED, RX_PERIODIC} rx_mode_t;

  localparam int        IDLE_LIMIT   = 2000;
  localparam int        DRAIN_CYCLES = 20;
  localparam int        RANDOM_ITEMS = 800;
  localparam int        RX_SPAN      = 150;
  localparam q30_word_t UNITY_Q30    = 64'd1 << 30;

  logic clk;
  logic rst_n;

  pmc_in_if  in_if ();
  pmc_out_if out_if ();

  pan_law_matrix_coefficients u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // predictor sine table, q1.30, one entry past the quarter wave
  q30_word_t  quarter_wave [0:SINE_TABLE_DEPTH];

  pan_item_t  pan_items [$];   // items still to be driven
  pmc_gains_t gains_due [$];   // predicted gains of items taken, oldest first

  int error_count;
  int idle_cycles;
  int rx_cycle;
  int burst_left;
  int gap_left;
  bit item_taken;              // input handshake seen at the last rising edge

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // taylor series of sin(x), x in q30, every term truncated at q30
  function automatic q30_word_t series_sine(q30_word_t x);
    q30_word_t x2;
    q30_word_t term;
    longint    acc;
    x2   = (x * x) >> 30;
    term = x;
    acc  = 0;
    for (int n = 0; n < 24 && term != 0; n++) begin
      if (n % 2 == 0) begin
        acc = acc + longint'(term);
      end else begin
        acc = acc - longint'(term);
      end
      term = ((term * x2) >> 30) / q30_word_t'((2 * n + 2) * (2 * n + 3));
    end
    if (acc < 0) begin
      return 0;
    end
    if (q30_word_t'(acc) > UNITY_Q30) begin
      return UNITY_Q30;
    end
    return q30_word_t'(acc);
  endfunction

  // entry k = sin(pi/2 * k / depth); kept monotonic, endpoints pinned
  task automatic fill_quarter_wave();
    q30_word_t x;
    q30_word_t v;
    quarter_wave[0] = 0;
    for (int k = 1; k < SINE_TABLE_DEPTH; k++) begin
      x = (HALF_PI_Q30 * q30_word_t'(k) + q30_word_t'(SINE_TABLE_DEPTH / 2))
          / q30_word_t'(SINE_TABLE_DEPTH);
      v = series_sine(x);
      if (v < quarter_wave[k-1]) begin
        v = quarter_wave[k-1];
      end
      quarter_wave[k] = v;
    end
    quarter_wave[SINE_TABLE_DEPTH] = UNITY_Q30;
  endtask

  // sine at quarter-wave phase u (PHASE_FULL = pi/2), linear interpolation
  function automatic q30_word_t sine_at(int u);
    q30_word_t pos;
    q30_word_t idx;
    q30_word_t frac;
    q30_word_t lo;
    q30_word_t hi;
    if (u > PHASE_FULL) begin
      u = PHASE_FULL;
    end
    pos  = q30_word_t'(u) * q30_word_t'(SINE_TABLE_DEPTH);
    idx  = pos >> 15;
    frac = pos & 64'd32767;
    if (idx >= q30_word_t'(SINE_TABLE_DEPTH)) begin
      return quarter_wave[SINE_TABLE_DEPTH];
    end
    lo = quarter_wave[idx];
    hi = quarter_wave[idx + 1];
    return lo + (((hi - lo) * frac + 64'd16384) >> 15);
  endfunction

  // q30 to output gain, optionally halved, rounded half up, cut to the field width
  function automatic gain_t gain_of(q30_word_t v, bit halve);
    int        shift;
    q30_word_t g;
    shift = 30 - GAIN_FRAC_BITS + int'(halve);
    g     = v;
    if (shift > 0) begin
      g = (v + (q30_word_t'(1) << (shift - 1))) >> shift;
    end
    return gain_t'(g);
  endfunction

  function automatic pmc_gains_t pan_matrix(pan_t pan, logic op);
    int         p;
    int         u;
    q30_word_t  ll;
    q30_word_t  rl;
    q30_word_t  lr;
    q30_word_t  rr;
    pmc_gains_t g;
    p = int'(pan);
    // saturate to full left / full right
    if (p > PAN_FULL) begin
      p = PAN_FULL;
    end
    if (p < -PAN_FULL) begin
      p = -PAN_FULL;
    end
    if (op == OP_MONO) begin
      // constant power: angle pi/4*(pan+1)
      u  = p + PAN_FULL;
      ll = sine_at(PHASE_FULL - u);
      rr = sine_at(u);
      rl = 0;
      lr = 0;
    end else if (p < 0) begin
      // balance toward left: right bleeds into left
      u  = -p * 2;
      ll = UNITY_Q30;
      rl = sine_at(u);
      lr = 0;
      rr = sine_at(PHASE_FULL - u);
    end else begin
      // balance toward right: left bleeds into right
      u  = p * 2;
      ll = sine_at(PHASE_FULL - u);
      rl = 0;
      lr = sine_at(u);
      rr = UNITY_Q30;
    end
    g.gain_left_to_left   = gain_of(ll, op == OP_BALANCE);
    g.gain_right_to_left  = gain_of(rl, op == OP_BALANCE);
    g.gain_left_to_right  = gain_of(lr, op == OP_BALANCE);
    g.gain_right_to_right = gain_of(rr, op == OP_BALANCE);
    return g;
  endfunction

  task automatic check_gain(string field, gain_t want, gain_t got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: pan items from the queue, bursts with random gaps, inputs move on falling edges
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    pan_item_t next_item;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !item_taken) begin
      // item offered but not taken yet: hold it
    end else if (gap_left > 0) begin
      gap_left--;
      in_if.valid <= 1'b0;
    end else if (pan_items.size() > 0) begin
      next_item = pan_items.pop_front();
      in_if.pan_position <= next_item.pan;
      in_if.opcode       <= next_item.op;
      in_if.valid        <= 1'b1;
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        // new burst; a third of the bursts run back to back with no gap
        burst_left = $urandom_range(0, 40);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // receiver stall pattern: free running, coin flip, mostly stalled, fixed duty cycle
  always @(negedge clk) begin
    rx_cycle++;
    case (rx_mode_t'((rx_cycle / RX_SPAN) % 4))
      RX_FREE:     out_if.ready <= 1'b1;
      RX_COIN:     out_if.ready <= ($urandom_range(0, 1) == 1);
      RX_STARVED:  out_if.ready <= ($urandom_range(0, 3) == 0);
      default:     out_if.ready <= ((rx_cycle % 9) < 4);
    endcase
  end

  // ---------------------------------------------------------------------------
  // monitor and scoreboard: both handshakes sampled on rising edges
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pmc_gains_t want;
    bit         gains_taken;
    item_taken  = rst_n && in_if.valid && in_if.ready;
    gains_taken = rst_n && out_if.valid && out_if.ready;

    // outputs first, so a result offered at the edge its input is taken is not matched to that input
    if (gains_taken) begin
      if (gains_due.size() == 0) begin
        error_count++;
        $display("%0t: gain item with nothing expected, actual %0d %0d %0d %0d", $time,
                 out_if.gain_left_to_left, out_if.gain_right_to_left,
                 out_if.gain_left_to_right, out_if.gain_right_to_right);
      end else begin
        want = gains_due.pop_front();
        check_gain("gain_left_to_left", want.gain_left_to_left, out_if.gain_left_to_left);
        check_gain("gain_right_to_left", want.gain_right_to_left, out_if.gain_right_to_left);
        check_gain("gain_left_to_right", want.gain_left_to_right, out_if.gain_left_to_right);
        check_gain("gain_right_to_right", want.gain_right_to_right,
                   out_if.gain_right_to_right);
      end
    end

    if (item_taken) begin
      gains_due.push_back(pan_matrix(in_if.pan_position, in_if.opcode));
    end

    // watchdog on cycles with no handshake at all
    if (!rst_n || item_taken || gains_taken) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_pan_law_matrix_coefficients failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    pan_item_t item;
    pan_t      edge_pans [12];

    clk                = 1'b0;
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.pan_position = '0;
    in_if.opcode       = OP_MONO;
    out_if.ready       = 1'b0;
    error_count        = 0;
    idle_cycles        = 0;
    rx_cycle           = 0;
    burst_left         = 0;
    gap_left           = 0;
    item_taken         = 1'b0;

    fill_quarter_wave();

    // directed: field extremes, saturation on both sides, full scale (unity and
    // unused cross gains), center, the smallest offsets around it, half scale and one odd point
    edge_pans = '{-16'sd32768, 16'sd32767, -16'sd16385, 16'sd16385, -16'sd16384,
                  16'sd16384, -16'sd1, 16'sd0, 16'sd1, -16'sd8192, 16'sd8192, 16'sd12345};
    foreach (edge_pans[i]) begin
      item.pan = edge_pans[i];
      item.op  = OP_MONO;
      pan_items.push_back(item);
      item.op  = OP_BALANCE;
      pan_items.push_back(item);
    end

    // random: mostly in range, with weight on the saturation knees and the center
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 9))
        0:       item.pan = pan_t'($urandom_range(0, 65535));
        1:       item.pan = pan_t'(PAN_FULL - 4 + int'($urandom_range(0, 8)));
        2:       item.pan = pan_t'(-PAN_FULL - 4 + int'($urandom_range(0, 8)));
        3:       item.pan = pan_t'(int'($urandom_range(0, 16)) - 8);
        default: item.pan = pan_t'(int'($urandom_range(0, 2 * PAN_FULL)) - PAN_FULL);
      endcase
      item.op = ($urandom_range(0, 1) == 1) ? OP_BALANCE : OP_MONO;
      pan_items.push_back(item);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all items driven and taken, every prediction checked
    do begin
      @(negedge clk);
    end while (pan_items.size() != 0 || in_if.valid || gains_due.size() != 0);

    // let any stray extra result show up
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("tb_pan_law_matrix_coefficients passed");
    end else begin
      $display("tb_pan_law_matrix_coefficients failed");
    end
    $finish;
  end

endmodule
